FILE: design/rgbc_pkg.sv
// Shared constants for the RGB nearest-centroid classifier.
package rgbc_pkg;

  localparam int NUM_CLASSES_DEF    = 7;
  localparam int COMPONENT_BITS_DEF = 10;

  // Writable centroid registers; a class beyond these keeps its reset centroid.
  localparam int NUM_REGS    = 7;
  localparam int MAX_CLASSES = 8;

  localparam int CLASS_BITS = 3;
  localparam int DIST_BITS  = 22;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

endpackage

FILE: design/rgbc_if.sv
// Valid/ready channel interfaces for sample requests and classification results.
interface rgbc_in_if #(
  parameter int COMPONENT_BITS = rgbc_pkg::COMPONENT_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red_sample;
  logic [COMPONENT_BITS-1:0] green_sample;
  logic [COMPONENT_BITS-1:0] blue_sample;

  modport source (output valid, red_sample, green_sample, blue_sample, input ready);
  modport sink   (input valid, red_sample, green_sample, blue_sample, output ready);
  modport mon    (input valid, ready, red_sample, green_sample, blue_sample);
endinterface

interface rgbc_out_if;
  logic                                valid;
  logic                                ready;
  logic [rgbc_pkg::CLASS_BITS-1:0]     class_index;
  logic [rgbc_pkg::DIST_BITS-1:0]      best_distance;

  modport source (output valid, class_index, best_distance, input ready);
  modport sink   (input valid, class_index, best_distance, output ready);
  modport mon    (input valid, ready, class_index, best_distance);
endinterface

FILE: design/rgb_nearest_centroid_classifier_unit.sv
// Top level of the RGB nearest-centroid colour classifier.
//
// Usage:
//   in_req  : valid/ready request channel, one raw RGB sample per request
//             (red_sample, green_sample, blue_sample, COMPONENT_BITS each).
//   out_res : valid/ready result channel, class_index (0 red, 1 green,
//             2 yellow, 3 blue, 4 black, 5 white, 6 gray) and best_distance,
//             the squared distance to that centroid, saturated to 22 bits.
//   cfg_*   : write-only centroid registers, index 0..6 in class order,
//             r in the low field, g in the middle, b in the high field.
//             Writes with an index of 7 are dropped. Write only while idle.
// Timing:
//   One request per cycle sustained while out_res is ready. A request goes
//   to the input register, then to the result register, which shows its
//   result; the whole distance/compare path lies between the two.
// Reset (rst_n low, synchronous): both pipeline valids clear, all centroids
//   return to zero. No clearing pass.
// Back-pressure: a stalled result holds in the result register; the input
//   register keeps taking requests until it is full as well, then in_req
//   ready drops. Ready is combinational from out_res ready.
module rgb_nearest_centroid_classifier_unit #(
  parameter int NUM_CLASSES    = rgbc_pkg::NUM_CLASSES_DEF,
  parameter int COMPONENT_BITS = rgbc_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  rgbc_in_if.sink                             in_req,
  rgbc_out_if.source                          out_res,
  input  logic                                cfg_we,
  input  logic [rgbc_pkg::CLASS_BITS-1:0]     cfg_index,
  input  logic [3*COMPONENT_BITS-1:0]         cfg_data
);

  localparam int CB   = COMPONENT_BITS;
  localparam int RW   = 3 * CB;
  localparam int DW   = 2 * CB + 2;
  localparam int OW   = rgbc_pkg::DIST_BITS;
  localparam int CMPW = (DW > OW) ? DW : OW;
  localparam int IW   = rgbc_pkg::CLASS_BITS;

  // centroid registers
  logic [RW-1:0] cent_r [NUM_CLASSES];

  // input stage
  logic          s1_v_r;
  logic [CB-1:0] s1_red_r, s1_green_r, s1_blue_r;
  logic          s1_adv;

  // result stage
  logic          out_v_r;
  logic [IW-1:0] out_idx_r;
  logic [OW-1:0] out_dist_r;
  logic [OW-1:0] out_dist_nxt;

  logic [DW-1:0] cls_dist [NUM_CLASSES];
  logic [IW-1:0] min_idx;
  logic [DW-1:0] min_dist;

  // Config writes. A class index without a register keeps zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) cent_r[i] <= '0;
    end else begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (cfg_we && (cfg_index == IW'(i)) && (i < rgbc_pkg::NUM_REGS)) begin
          cent_r[i] <= cfg_data;
        end
      end
    end
  end

  // Handshake: stage 1 moves on when the result register is empty or drained.
  assign s1_adv       = !out_v_r || out_res.ready;
  assign in_req.ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_req.ready) s1_v_r  <= in_req.valid;
      if (s1_adv)       out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_red_r   <= in_req.red_sample;
      s1_green_r <= in_req.green_sample;
      s1_blue_r  <= in_req.blue_sample;
    end
    if (s1_adv && s1_v_r) begin
      out_idx_r  <= min_idx;
      out_dist_r <= out_dist_nxt;
    end
  end

  // One distance unit per class, all in parallel.
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_dist
    rgbc_dist #(
      .COMPONENT_BITS(CB)
    ) u_dist (
      .red     (s1_red_r),
      .green   (s1_green_r),
      .blue    (s1_blue_r),
      .centroid(cent_r[c]),
      .sq_dist (cls_dist[c])
    );
  end

  rgbc_argmin #(
    .NUM_CLASSES(NUM_CLASSES),
    .DIST_W     (DW)
  ) u_argmin (
    .cand_dist(cls_dist),
    .min_idx  (min_idx),
    .min_dist (min_dist)
  );

  // Saturate only on the way out; the class choice used the exact value.
  always_comb begin
    if (CMPW'(min_dist) > CMPW'(rgbc_pkg::DIST_MAX)) begin
      out_dist_nxt = rgbc_pkg::DIST_MAX;
    end else begin
      out_dist_nxt = OW'(CMPW'(min_dist));
    end
  end

  assign out_res.valid         = out_v_r;
  assign out_res.class_index   = out_idx_r;
  assign out_res.best_distance = out_dist_r;

endmodule

FILE: design/rgbc_dist.sv
// Squared Euclidean distance from one sample to one packed centroid.
module rgbc_dist #(
  parameter int COMPONENT_BITS = rgbc_pkg::COMPONENT_BITS_DEF
) (
  input  logic [COMPONENT_BITS-1:0]   red,
  input  logic [COMPONENT_BITS-1:0]   green,
  input  logic [COMPONENT_BITS-1:0]   blue,
  input  logic [3*COMPONENT_BITS-1:0] centroid,
  output logic [2*COMPONENT_BITS+1:0] sq_dist
);

  localparam int CB = COMPONENT_BITS;
  localparam int SW = 2 * CB;
  localparam int DW = 2 * CB + 2;

  logic [CB-1:0] c_r, c_g, c_b;
  logic [CB-1:0] d_r, d_g, d_b;
  logic [SW-1:0] sq_r, sq_g, sq_b;

  assign c_r = centroid[CB-1:0];
  assign c_g = centroid[2*CB-1:CB];
  assign c_b = centroid[3*CB-1:2*CB];

  // absolute differences
  assign d_r = (c_r >= red)   ? (c_r - red)   : (red - c_r);
  assign d_g = (c_g >= green) ? (c_g - green) : (green - c_g);
  assign d_b = (c_b >= blue)  ? (c_b - blue)  : (blue - c_b);

  assign sq_r = SW'(d_r) * SW'(d_r);
  assign sq_g = SW'(d_g) * SW'(d_g);
  assign sq_b = SW'(d_b) * SW'(d_b);

  assign sq_dist = DW'(sq_r) + DW'(sq_g) + DW'(sq_b);

endmodule

FILE: design/rgbc_argmin.sv
// Three-level compare tree picking the smallest distance; lower index wins ties.
module rgbc_argmin #(
  parameter int NUM_CLASSES = rgbc_pkg::NUM_CLASSES_DEF,
  parameter int DIST_W      = 2 * rgbc_pkg::COMPONENT_BITS_DEF + 2
) (
  input  logic [DIST_W-1:0]               cand_dist [NUM_CLASSES],
  output logic [rgbc_pkg::CLASS_BITS-1:0] min_idx,
  output logic [DIST_W-1:0]               min_dist
);

  localparam int LEAVES = rgbc_pkg::MAX_CLASSES;
  localparam int CW     = rgbc_pkg::CLASS_BITS;

  logic              l0_v [LEAVES];
  logic [CW-1:0]     l0_i [LEAVES];
  logic [DIST_W-1:0] l0_d [LEAVES];
  logic              l1_v [LEAVES/2];
  logic [CW-1:0]     l1_i [LEAVES/2];
  logic [DIST_W-1:0] l1_d [LEAVES/2];
  logic              l2_v [LEAVES/4];
  logic [CW-1:0]     l2_i [LEAVES/4];
  logic [DIST_W-1:0] l2_d [LEAVES/4];
  logic              take_r1 [LEAVES/2];
  logic              take_r2 [LEAVES/4];
  logic              take_r3;

  always_comb begin
    // leaves; unused slots are marked empty
    for (int i = 0; i < LEAVES; i++) begin
      l0_v[i] = 1'b0;
      l0_i[i] = CW'(i);
      l0_d[i] = '0;
      if (i < NUM_CLASSES) begin
        l0_v[i] = 1'b1;
        l0_d[i] = cand_dist[i];
      end
    end
    // right side replaces left only when strictly smaller
    for (int i = 0; i < LEAVES/2; i++) begin
      take_r1[i] = l0_v[2*i+1] && (!l0_v[2*i] || (l0_d[2*i+1] < l0_d[2*i]));
      l1_v[i]    = l0_v[2*i] || l0_v[2*i+1];
      l1_i[i]    = take_r1[i] ? l0_i[2*i+1] : l0_i[2*i];
      l1_d[i]    = take_r1[i] ? l0_d[2*i+1] : l0_d[2*i];
    end
    for (int i = 0; i < LEAVES/4; i++) begin
      take_r2[i] = l1_v[2*i+1] && (!l1_v[2*i] || (l1_d[2*i+1] < l1_d[2*i]));
      l2_v[i]    = l1_v[2*i] || l1_v[2*i+1];
      l2_i[i]    = take_r2[i] ? l1_i[2*i+1] : l1_i[2*i];
      l2_d[i]    = take_r2[i] ? l1_d[2*i+1] : l1_d[2*i];
    end
    take_r3  = l2_v[1] && (!l2_v[0] || (l2_d[1] < l2_d[0]));
    min_idx  = take_r3 ? l2_i[1] : l2_i[0];
    min_dist = take_r3 ? l2_d[1] : l2_d[0];
  end

endmodule

FILE: design/rgbc_checker.sv
// Port-level assertions for the classifier, bound to the top level.
module rgbc_checker #(
  parameter int NUM_CLASSES = rgbc_pkg::NUM_CLASSES_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rgbc_pkg::CLASS_BITS-1:0] out_class
);

  // Result cannot vanish before it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Every accepted request has a result showing once it has passed both registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result two cycles after request");

  // Class code always names a configured class.
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_class) < NUM_CLASSES))
    else $error("class_index out of range");

  // Reset empties the pipeline.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rgb_nearest_centroid_classifier_unit rgbc_checker #(
  .NUM_CLASSES(NUM_CLASSES)
) u_rgbc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_req.valid),
  .in_ready (in_req.ready),
  .out_valid(out_res.valid),
  .out_ready(out_res.ready),
  .out_class(out_res.class_index)
);

FILE: tb/sv/tb_top.sv
// Self-checking bench for the RGB nearest-centroid classifier: directed table plus random phases.
module tb_top;

  localparam int CLASS_BITS  = rgbc_pkg::CLASS_BITS;
  localparam int DIST_BITS   = rgbc_pkg::DIST_BITS;
  localparam int NUM_REGS    = rgbc_pkg::NUM_REGS;
  localparam int MAX_CLASSES = rgbc_pkg::MAX_CLASSES;
  localparam logic [DIST_BITS-1:0] DIST_MAX = rgbc_pkg::DIST_MAX;

  localparam int NUM_CLS     = rgbc_pkg::NUM_CLASSES_DEF;
  localparam int CB          = rgbc_pkg::COMPONENT_BITS_DEF;
  localparam int ITEMS_PHASE = 156;           // 8 phases -> about 1250 random requests
  localparam int NUM_PHASES  = 8;
  localparam int CALM_PHASE  = 3;             // no idling on either side in this phase
  localparam int IDLE_PCT    = 26;
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES = 4;             // idle tail after the last result

  typedef logic [CB-1:0]   comp_t;
  typedef logic [3*CB-1:0] rgb_t;             // {b, g, r}, same packing as a centroid

  // Class codes in register order; the register index of a class is its code.
  typedef enum logic [CLASS_BITS-1:0] {
    CLS_RED, CLS_GREEN, CLS_YELLOW, CLS_BLUE, CLS_BLACK, CLS_WHITE, CLS_GRAY
  } colour_class_e;

  // First index past the register file; writes there must be dropped.
  localparam logic [CLASS_BITS-1:0] IDX_UNMAPPED = CLASS_BITS'(NUM_REGS);

  typedef enum int {
    STYLE_SCATTER, STYLE_SAME, STYLE_CORNERS, STYLE_CLUSTER, STYLE_TWINS, STYLE_SATURATED
  } phase_style_e;

  typedef struct packed {
    logic [CLASS_BITS-1:0] class_index;
    logic [DIST_BITS-1:0]  best_distance;
  } verdict_t;

  // One row of the directed table: a register write or a sample request.
  typedef struct packed {
    bit                    is_write;
    logic [CLASS_BITS-1:0] reg_idx;
    rgb_t                  value;
    bit                    typed;
    verdict_t              want;
  } step_t;

  localparam comp_t FULL = '1;
  localparam comp_t HALF = comp_t'(1 << (CB - 1));

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CLASS_BITS-1:0] cfg_index;
  logic [3*CB-1:0]       cfg_data;

  rgbc_in_if  #(.COMPONENT_BITS(CB)) in_ch ();
  rgbc_out_if                        out_ch ();

  rgb_nearest_centroid_classifier_unit #(
    .NUM_CLASSES    (NUM_CLS),
    .COMPONENT_BITS (CB)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the centroid registers, updated at the write edge.
  rgb_t     centroid_shadow [MAX_CLASSES];
  // Verdicts owed by the block, oldest first.
  verdict_t pending_verdicts [$];
  step_t    plan [$];

  bit calm;                                   // suppresses idling on both sides
  int mismatches;
  int results_checked;
  int requests_sent;
  int directed_sent;
  int writes_done;
  int cycle_count;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned sq_gap(comp_t a, comp_t b);
    longint unsigned d;
    d = (a >= b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
    return d * d;
  endfunction

  // Nearest centroid by exact squared distance; strict less-than keeps the
  // lowest class on a tie. Distance saturates at the output width.
  function automatic verdict_t nearest_class(rgb_t px);
    longint unsigned best;
    longint unsigned d;
    int              best_idx;
    verdict_t        v;
    best     = 0;
    best_idx = 0;
    for (int i = 0; i < NUM_CLS; i++) begin
      d = sq_gap(centroid_shadow[i][CB-1:0],      px[CB-1:0])
        + sq_gap(centroid_shadow[i][2*CB-1:CB],   px[2*CB-1:CB])
        + sq_gap(centroid_shadow[i][3*CB-1:2*CB], px[3*CB-1:2*CB]);
      if (i == 0 || d < best) begin
        best     = d;
        best_idx = i;
      end
    end
    v.class_index   = CLASS_BITS'(best_idx);
    v.best_distance = (best > longint'(DIST_MAX)) ? DIST_MAX : best[DIST_BITS-1:0];
    return v;
  endfunction

  function automatic rgb_t pack_rgb(comp_t r, comp_t g, comp_t b);
    return {b, g, r};
  endfunction

  function automatic comp_t clamp_comp(int v);
    if (v < 0)
      return '0;
    if (v > int'(FULL))
      return FULL;
    return comp_t'(v);
  endfunction

  function automatic verdict_t make_verdict(colour_class_e cls, int sq_len);
    verdict_t v;
    v.class_index   = cls;
    v.best_distance = DIST_BITS'(sq_len);
    return v;
  endfunction

  // Random sample: half near or on a centroid, or halfway between two,
  // so decisions land close to the class boundaries; the rest is noise or extremes.
  function automatic rgb_t random_pixel();
    rgb_t  a;
    rgb_t  c;
    rgb_t  px;
    comp_t ca;
    comp_t cc;
    int    pick;
    pick = $urandom_range(0, 99);
    a    = centroid_shadow[$urandom_range(0, NUM_CLS - 1)];
    c    = centroid_shadow[$urandom_range(0, NUM_CLS - 1)];
    for (int k = 0; k < 3; k++) begin
      ca = a[k*CB +: CB];
      cc = c[k*CB +: CB];
      if (pick < 40)
        px[k*CB +: CB] = comp_t'($urandom);
      else if (pick < 70)
        px[k*CB +: CB] = clamp_comp(int'(ca) + int'($urandom_range(0, 16)) - 8);
      else if (pick < 80)
        px[k*CB +: CB] = ca;
      else if (pick < 90)
        px[k*CB +: CB] = $urandom_range(0, 1) ? FULL : ($urandom_range(0, 1) ? '0 :
                                                        comp_t'($urandom));
      else
        px[k*CB +: CB] = comp_t'(({1'b0, ca} + {1'b0, cc}) >> 1);
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Register write: one edge with cfg_we high. The caller's next request
  // lowers cfg_we, so back-to-back writes never toggle it inside one step.
  task automatic write_centroid(logic [CLASS_BITS-1:0] idx, rgb_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx < NUM_REGS)
      centroid_shadow[idx] = value;
    writes_done++;
  endtask

  // Stop requesting and wait until every owed result has been checked;
  // each request yields exactly one result, so the block is then idle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // One sample request. Valid stays high after acceptance so that
  // consecutive requests can go back to back.
  task automatic send_sample(rgb_t px, bit typed, verdict_t want);
    cfg_we <= 1'b0;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.red_sample   <= px[CB-1:0];
    in_ch.green_sample <= px[2*CB-1:CB];
    in_ch.blue_sample  <= px[3*CB-1:2*CB];
    do
      @(posedge clk);
    while (!in_ch.ready);
    pending_verdicts.push_back(typed ? want : nearest_class(px));
    requests_sent++;
  endtask

  task automatic add_write(logic [CLASS_BITS-1:0] idx, rgb_t value);
    step_t s;
    s          = '0;
    s.is_write = 1'b1;
    s.reg_idx  = idx;
    s.value    = value;
    plan.push_back(s);
  endtask

  task automatic add_sample(rgb_t px);
    step_t s;
    s       = '0;
    s.value = px;
    plan.push_back(s);
  endtask

  // Sample whose verdict is obvious by inspection.
  task automatic add_checked(rgb_t px, colour_class_e cls, int sq_len);
    step_t s;
    s       = '0;
    s.value = px;
    s.typed = 1'b1;
    s.want  = make_verdict(cls, sq_len);
    plan.push_back(s);
  endtask

  // Loads all seven centroids in one of several shapes, then pokes the
  // unmapped index, which the block must drop.
  task automatic program_phase(phase_style_e style);
    rgb_t base;
    rgb_t value;
    base = rgb_t'($urandom);
    for (int i = 0; i < NUM_REGS; i++) begin
      case (style)
        STYLE_SAME:      value = base;
        STYLE_SATURATED: value = '1;
        STYLE_CORNERS: begin
          for (int k = 0; k < 3; k++)
            value[k*CB +: CB] = $urandom_range(0, 1) ? FULL : '0;
        end
        STYLE_CLUSTER: begin
          for (int k = 0; k < 3; k++)
            value[k*CB +: CB] = clamp_comp(int'(base[k*CB +: CB]) +
                                           int'($urandom_range(0, 8)) - 4);
        end
        STYLE_TWINS: begin
          // Copies of a lower class force exact ties between registers.
          if (i > 0 && $urandom_range(0, 1))
            value = centroid_shadow[$urandom_range(0, i - 1)];
          else
            value = rgb_t'($urandom);
        end
        default:         value = rgb_t'($urandom);
      endcase
      write_centroid(CLASS_BITS'(i), value);
    end
    write_centroid(IDX_UNMAPPED, rgb_t'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, every accepted result checked against
  // the oldest owed verdict.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending: class %0d distance %0d",
                 $time, out_ch.class_index, out_ch.best_distance);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.class_index !== want.class_index) begin
          mismatches++;
          $display("%0t: class_index expected %0d actual %0d",
                   $time, want.class_index, out_ch.class_index);
        end
        if (out_ch.best_distance !== want.best_distance) begin
          mismatches++;
          $display("%0t: best_distance expected %0d actual %0d",
                   $time, want.best_distance, out_ch.best_distance);
        end
      end
    end
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("rgb_nearest_centroid_classifier_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.red_sample   = '0;
    in_ch.green_sample = '0;
    in_ch.blue_sample  = '0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    calm               = 1'b0;
    for (int i = 0; i < MAX_CLASSES; i++)
      centroid_shadow[i] = '0;

    // Directed table. After reset every centroid is zero, so class 0 wins
    // every tie and the distance is just the sample's squared length.
    add_checked(pack_rgb('0, '0, '0), CLS_RED, 0);
    add_checked(pack_rgb(FULL, FULL, FULL), CLS_RED, 3 * 1023 * 1023);
    add_checked(pack_rgb(FULL, '0, '0), CLS_RED, 1023 * 1023);
    add_sample(pack_rgb(10'd682, 10'd341, FULL));
    // Named palette: every centroid on a cube corner, gray in the middle.
    add_write(CLS_RED,    pack_rgb(FULL, '0,   '0));
    add_write(CLS_GREEN,  pack_rgb('0,   FULL, '0));
    add_write(CLS_YELLOW, pack_rgb(FULL, FULL, '0));
    add_write(CLS_BLUE,   pack_rgb('0,   '0,   FULL));
    add_write(CLS_BLACK,  pack_rgb('0,   '0,   '0));
    add_write(CLS_WHITE,  pack_rgb(FULL, FULL, FULL));
    add_write(CLS_GRAY,   pack_rgb(HALF, HALF, HALF));
    // Out-of-range index must not disturb any centroid.
    add_write(IDX_UNMAPPED, pack_rgb(10'd77, 10'd88, 10'd99));
    // A sample on each centroid hits it exactly.
    add_checked(pack_rgb(FULL, '0,   '0),   CLS_RED,    0);
    add_checked(pack_rgb('0,   FULL, '0),   CLS_GREEN,  0);
    add_checked(pack_rgb(FULL, FULL, '0),   CLS_YELLOW, 0);
    add_checked(pack_rgb('0,   '0,   FULL), CLS_BLUE,   0);
    add_checked(pack_rgb('0,   '0,   '0),   CLS_BLACK,  0);
    add_checked(pack_rgb(FULL, FULL, FULL), CLS_WHITE,  0);
    add_checked(pack_rgb(HALF, HALF, HALF), CLS_GRAY,   0);
    // Equidistant from black and gray: the lower class, black, wins.
    add_checked(pack_rgb(10'd256, 10'd256, 10'd256), CLS_BLACK, 3 * 256 * 256);
    add_sample(pack_rgb(10'd768, 10'd768, 10'd768));
    add_sample(pack_rgb(10'd1000, 10'd20, 10'd30));
    add_sample(pack_rgb(10'd10, 10'd1010, 10'd5));
    add_sample(pack_rgb(10'd900, 10'd900, 10'd50));
    // All centroids equal: seven-way tie, class 0 always.
    for (int i = 0; i < NUM_REGS; i++)
      add_write(CLASS_BITS'(i), pack_rgb(10'd300, 10'd600, 10'd900));
    add_checked(pack_rgb(10'd300, 10'd600, 10'd900), CLS_RED, 0);
    add_checked(pack_rgb('0, '0, '0), CLS_RED, 1260000);
    add_checked(pack_rgb(FULL, FULL, FULL), CLS_RED, 716787);

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[n]) begin
      if (plan[n].is_write) begin
        drain_results();
        write_centroid(plan[n].reg_idx, plan[n].value);
      end else begin
        send_sample(plan[n].value, plan[n].typed, plan[n].want);
        directed_sent++;
      end
    end

    // Random phases, each under a fresh centroid set.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      calm = (p == CALM_PHASE);
      program_phase(phase_style_e'(p % 6));
      for (int k = 0; k < ITEMS_PHASE; k++)
        send_sample(random_pixel(), 1'b0, '0);
    end

    drain_results();
    calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d directed and %0d random sample requests, %0d register writes",
             directed_sent, requests_sent - directed_sent, writes_done);
    $display("%0d centroid settings incl. ties, corners and saturated; %0d results checked",
             NUM_PHASES + 3, results_checked);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("rgb_nearest_centroid_classifier_unit: match");
    end else begin
      $display("rgb_nearest_centroid_classifier_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: rgb_nearest_centroid_classifier_unit.f
design/rgbc_pkg.sv
design/rgbc_if.sv
design/rgbc_dist.sv
design/rgbc_argmin.sv
design/rgb_nearest_centroid_classifier_unit.sv
design/rgbc_checker.sv
tb/sv/tb_top.sv
